/* rtl/scalar_instruction_decoder_macros.svh */
// Assertion macros for the scalar instruction decoder.
// No dependencies.
`ifndef SCALAR_INSTRUCTION_DECODER_MACROS_SVH
`define SCALAR_INSTRUCTION_DECODER_MACROS_SVH

`define SID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define SID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sid_pkg.sv */
// Package for the scalar instruction decoder: item types, codes, lookup functions.
// No dependencies.
package sid_pkg;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_SCALAR = 2'd1, ST_UNSUPPORTED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FMT_ONE = 3'd0, FMT_TWO = 3'd1, FMT_IMM = 3'd2, FMT_CMP = 3'd3, FMT_CTL = 3'd4
  } format_e;

  typedef enum logic [1:0] {
    DK_SREG = 2'd0, DK_NONE = 2'd1, DK_SCC = 2'd2
  } dest_kind_e;

  localparam logic [6:0] SEL_ONE = 7'h7d;
  localparam logic [6:0] SEL_CMP = 7'h7e;
  localparam logic [6:0] SEL_CTL = 7'h7f;
  localparam logic [6:0] SEL_IMM_LO = 7'h60;

  localparam logic [6:0] OP_SADD_I32 = 7'd31;
  localparam logic [6:0] OP_SMOVK = 7'd94;
  localparam logic [6:0] OP_SMULK = 7'd95;
  localparam logic [6:0] OP_SSETREG = 7'd96;
  localparam logic [6:0] OP_SWAIT = 7'd97;
  localparam logic [6:0] OP_LOOP_BEGIN = 7'd98;
  localparam logic [6:0] OP_LOOP_END = 7'd99;
  localparam logic [6:0] OP_GETPC = 7'd18;
  localparam logic [6:0] OP_SETPC = 7'd19;
  localparam logic [6:0] OP_TRAP = 7'd113;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic [29:0] word_index;
  } sid_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  format;
    logic [6:0]  operation;
    logic [1:0]  dest_kind;
    logic [6:0]  dest_field;
    logic [7:0]  src0_code;
    logic [7:0]  src1_code;
    logic [31:0] immediate;
    logic [1:0]  immediate_slot;
    logic [1:0]  source_count;
    logic [1:0]  dest_dwords;
    logic [31:0] branch_target;
  } sid_out_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] op;
  } lookup_t;

  function automatic lookup_t one_src_lookup(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    r.op = 7'd0;
    unique case (c)
      8'h03: r.op = 7'd0;  8'h04: r.op = 7'd1;  8'h06: r.op = 7'd2;
      8'h07: r.op = 7'd3;  8'h08: r.op = 7'd4;  8'h09: r.op = 7'd5;
      8'h0a: r.op = 7'd6;  8'h0b: r.op = 7'd7;  8'h0f: r.op = 7'd8;
      8'h10: r.op = 7'd9;  8'h13: r.op = 7'd10; 8'h14: r.op = 7'd11;
      8'h15: r.op = 7'd12; 8'h16: r.op = 7'd13; 8'h1b: r.op = 7'd14;
      8'h1c: r.op = 7'd15; 8'h1d: r.op = 7'd16; 8'h1e: r.op = 7'd17;
      8'h1f: r.op = 7'd18; 8'h20: r.op = 7'd19; 8'h24: r.op = 7'd20;
      8'h28: r.op = 7'd21; 8'h2d: r.op = 7'd22; 8'h34: r.op = 7'd23;
      8'h37: r.op = 7'd24; 8'h3b: r.op = 7'd25; 8'h3c: r.op = 7'd26;
      8'h40: r.op = 7'd27; 8'h44: r.op = 7'd28;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t two_src_lookup(input logic [6:0] c);
    lookup_t r;
    r.hit = 1'b1;
    r.op = 7'd0;
    if (c <= 7'h0b) r.op = 7'd29 + c;
    else if (c >= 7'h0e && c <= 7'h22) r.op = 7'd41 + (c - 7'h0e);
    else if (c >= 7'h24 && c <= 7'h29) r.op = 7'd62 + (c - 7'h24);
    else if (c == 7'h2c) r.op = 7'd68;
    else if (c >= 7'h2e && c <= 7'h36) r.op = 7'd69 + (c - 7'h2e);
    else r.hit = 1'b0;
    return r;
  endfunction

  function automatic lookup_t cmp_lookup(input logic [6:0] c);
    lookup_t r;
    r.hit = 1'b1;
    r.op = 7'd0;
    if (c <= 7'h0d) r.op = 7'd78 + c;
    else if (c == 7'h12) r.op = 7'd92;
    else if (c == 7'h13) r.op = 7'd93;
    else r.hit = 1'b0;
    return r;
  endfunction

  function automatic lookup_t imm_lookup(input logic [4:0] c);
    lookup_t r;
    r.hit = 1'b1;
    r.op = 7'd0;
    unique case (c) inside
      5'h00: r.op = OP_SMOVK;
      5'h03: r.op = 7'd78; 5'h04: r.op = 7'd79; 5'h05: r.op = 7'd80;
      5'h06: r.op = 7'd81; 5'h07: r.op = 7'd82; 5'h08: r.op = 7'd83;
      5'h09: r.op = 7'd84; 5'h0a: r.op = 7'd85; 5'h0b: r.op = 7'd86;
      5'h0c: r.op = 7'd87; 5'h0d: r.op = 7'd88; 5'h0e: r.op = 7'd89;
      5'h0f: r.op = OP_SADD_I32;
      5'h10: r.op = OP_SMULK;
      5'h13: r.op = OP_SSETREG;
      [5'h17:5'h1a]: r.op = OP_SWAIT;
      5'h1b: r.op = OP_LOOP_BEGIN;
      5'h1c: r.op = OP_LOOP_END;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t ctl_lookup(input logic [6:0] c);
    lookup_t r;
    r.hit = 1'b1;
    r.op = 7'd0;
    unique case (c)
      7'h00: r.op = 7'd100; 7'h01: r.op = 7'd101; 7'h02: r.op = 7'd102;
      7'h04: r.op = 7'd103; 7'h05: r.op = 7'd104; 7'h06: r.op = 7'd105;
      7'h07: r.op = 7'd106; 7'h08: r.op = 7'd107; 7'h09: r.op = 7'd108;
      7'h0a: r.op = 7'd109; 7'h0c: r.op = OP_SWAIT; 7'h0e: r.op = 7'd110;
      7'h0f: r.op = 7'd111; 7'h10: r.op = 7'd112; 7'h12: r.op = OP_TRAP;
      7'h16: r.op = 7'd114; 7'h20: r.op = 7'd115; 7'h23: r.op = 7'd116;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_wide(input logic [6:0] op);
    logic w;
    case (op) inside
      7'd1, 7'd2, 7'd4, 7'd6, 7'd15, 7'd17, 7'd18, 7'd20, 7'd21, 7'd22, 7'd24,
      7'd25, 7'd40, 7'd42, 7'd44, 7'd46, 7'd48, 7'd50, 7'd52, 7'd54, 7'd56,
      7'd58, 7'd60, 7'd63, 7'd67: w = 1'b1;
      default: w = 1'b0;
    endcase
    return w;
  endfunction

  function automatic logic is_wait_like(input logic [6:0] op);
    logic w;
    case (op) inside
      7'd100, OP_SWAIT, 7'd116, 7'd110, 7'd111, 7'd112, OP_TRAP, 7'd114,
      7'd115: w = 1'b1;
      default: w = 1'b0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/sid_decode.sv */
// Combinational decode of one instruction word into a result record.
// Depends on sid_pkg.
module sid_decode import sid_pkg::*; (
  input  sid_in_t  item_i,
  output sid_out_t rec_o
);

  logic [31:0] w;
  logic [31:0] pc;
  logic [6:0]  sel;
  logic [6:0]  dfield;
  logic [7:0]  s0;
  logic [7:0]  s1;
  logic [15:0] k16;
  logic [31:0] sx16;
  logic [31:0] zx16;
  logic [31:0] imm;
  logic [4:0]  icode;
  lookup_t     lk;
  format_e     fmt;

  assign w      = item_i.instruction_word;
  assign pc     = {item_i.word_index, 2'b00};
  assign sel    = w[29:23];
  assign dfield = w[22:16];
  assign s0     = w[7:0];
  assign s1     = w[15:8];
  assign k16    = w[15:0];
  assign icode  = sel[4:0];
  assign sx16   = {{16{k16[15]}}, k16};
  assign zx16   = {16'h0000, k16};
  assign imm    = (icode >= 5'h09 && icode <= 5'h0e) ? zx16 : sx16;

  always_comb begin
    fmt = FMT_TWO;
    lk  = two_src_lookup(sel);
    if (sel == SEL_ONE) begin
      fmt = FMT_ONE;
      lk  = one_src_lookup(s1);
    end else if (sel == SEL_CMP) begin
      fmt = FMT_CMP;
      lk  = cmp_lookup(dfield);
    end else if (sel == SEL_CTL) begin
      fmt = FMT_CTL;
      lk  = ctl_lookup(dfield);
    end else if (sel >= SEL_IMM_LO) begin
      fmt = FMT_IMM;
      lk  = imm_lookup(icode);
    end
  end

  always_comb begin
    rec_o = '0;
    rec_o.dest_dwords = 2'd1;
    if (w[31:30] != 2'b10) begin
      rec_o.status = ST_NOT_SCALAR;
    end else if (!lk.hit) begin
      rec_o.status = ST_UNSUPPORTED;
      rec_o.format = fmt;
    end else begin
      rec_o.status      = ST_OK;
      rec_o.format      = fmt;
      rec_o.operation   = lk.op;
      rec_o.dest_dwords = is_wide(lk.op) ? 2'd2 : 2'd1;
      unique case (fmt)
        FMT_ONE: begin
          if (lk.op == OP_GETPC) begin
            rec_o.dest_field = dfield;
          end else if (lk.op == OP_SETPC) begin
            rec_o.dest_kind = DK_NONE;
            rec_o.src0_code = s0;
            rec_o.source_count = 2'd1;
          end else begin
            rec_o.dest_field = dfield;
            rec_o.src0_code = s0;
            rec_o.source_count = 2'd1;
          end
        end
        FMT_TWO: begin
          rec_o.dest_field = dfield;
          rec_o.src0_code = s0;
          rec_o.src1_code = s1;
          rec_o.source_count = 2'd2;
        end
        FMT_CMP: begin
          rec_o.dest_kind = DK_SCC;
          rec_o.src0_code = s0;
          rec_o.src1_code = s1;
          rec_o.source_count = 2'd2;
        end
        FMT_CTL: begin
          rec_o.dest_kind = DK_NONE;
          rec_o.immediate = (lk.op == OP_TRAP) ? {24'h0, k16[7:0]} : zx16;
          rec_o.immediate_slot = 2'd1;
          rec_o.source_count = is_wait_like(lk.op) ? 2'd1 : 2'd0;
          rec_o.branch_target = pc + 32'd4 + {sx16[29:0], 2'b00};
        end
        FMT_IMM: begin
          if (lk.op == OP_SMOVK) begin
            rec_o.dest_field = dfield;
            rec_o.immediate = imm;
            rec_o.immediate_slot = 2'd1;
            rec_o.source_count = 2'd1;
          end else if (lk.op == OP_LOOP_BEGIN || lk.op == OP_LOOP_END) begin
            rec_o.dest_field = dfield;
            rec_o.immediate = imm;
            rec_o.immediate_slot = 2'd1;
            rec_o.source_count = 2'd1;
            rec_o.branch_target = pc + 32'd4 + {imm[29:0], 2'b00};
          end else if (lk.op == OP_SWAIT) begin
            rec_o.dest_kind = DK_NONE;
            rec_o.immediate = zx16;
            rec_o.immediate_slot = 2'd1;
            rec_o.source_count = 2'd1;
          end else if (lk.op == OP_SSETREG) begin
            rec_o.dest_kind = DK_NONE;
            rec_o.src0_code = {1'b0, dfield};
            rec_o.immediate = zx16;
            rec_o.immediate_slot = 2'd2;
            rec_o.source_count = 2'd2;
          end else if (lk.op == OP_SADD_I32 || lk.op == OP_SMULK) begin
            rec_o.dest_field = dfield;
            rec_o.src0_code = {1'b0, dfield};
            rec_o.immediate = imm;
            rec_o.immediate_slot = 2'd2;
            rec_o.source_count = 2'd2;
          end else begin
            rec_o.dest_kind = DK_SCC;
            rec_o.src0_code = {1'b0, dfield};
            rec_o.immediate = imm;
            rec_o.immediate_slot = 2'd2;
            rec_o.source_count = 2'd2;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/scalar_instruction_decoder.sv */
// Scalar instruction decoder top level: input register, decode, result register.
// The item is captured in the input register, decoded combinationally, then captured in the
// result register; the result strobe done_o rises together with the new result register contents.
// Throughput: one item per cycle; busy is tied low, the receiver cannot stall.
// Reset clears only the valid flags; payload registers are not reset.
// Depends on sid_pkg, sid_decode and scalar_instruction_decoder_macros.svh.
`include "scalar_instruction_decoder_macros.svh"
module scalar_instruction_decoder import sid_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sid_in_t  item_i,
  output logic     done_o,
  output sid_out_t result_o
);

  logic     in_vld_q;
  sid_in_t  in_q;
  logic     out_vld_q;
  sid_out_t out_q;
  sid_out_t rec_d;
  logic     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= item_i;
    if (in_vld_q) out_q <= rec_d;
  end

  sid_decode u_dec (
    .item_i (in_q),
    .rec_o  (rec_d)
  );

  assign done_o   = out_vld_q;
  assign result_o = out_q;

  `SID_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_vld_q, done_o,
    "result strobe missing after a registered item")
  `SID_ASSERT(a_dwords, clk_i, rst_ni,
    !done_o || result_o.dest_dwords == 2'd1 || result_o.dest_dwords == 2'd2,
    "dest_dwords out of range")
  `SID_ASSERT(a_reject_clean, clk_i, rst_ni,
    !(done_o && result_o.status == ST_NOT_SCALAR) || result_o.operation == 7'd0,
    "rejected word carries an operation")
  `SID_ASSERT(a_slot_imm, clk_i, rst_ni,
    !(done_o && result_o.immediate_slot == 2'd0) || result_o.immediate == 32'd0,
    "immediate set without a slot")

endmodule
